// File: rtl/core/sfs_pkg.sv
// sfs_pkg: shared widths, request and mode codes, config and control structs
// for the sprite frame sequencer. No dependencies.

package sfs_pkg;

  // field and storage widths
  localparam int ACC_W      = 32;
  localparam int FRAME_W    = 8;
  localparam int MAX_FRAMES = 256;
  localparam int CNT_W      = 9;
  localparam int FT_W       = 16;
  localparam int COL_W      = 7;
  localparam int DIM_W      = 12;
  localparam int ORG_W      = 4;
  localparam int MODE_W     = 3;
  localparam int REQ_W      = 2;
  localparam int DELTA_W    = 16;
  localparam int RX_W       = 18;
  localparam int RY_W       = 20;
  localparam int OH_W       = 13;
  localparam int STEP_W     = $clog2(ACC_W);
  localparam int FIDX_W     = $clog2(FRAME_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PLAY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PAUSE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_MODE  = 2'd3;

  // animation modes
  localparam logic [MODE_W-1:0] MODE_LOOP_FWD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOOP_BWD = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ONCE_FWD = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ONCE_BWD = 3'd3;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIME   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_MODE  = 3'd6;

  typedef struct packed {
    logic               enable;
    logic [FT_W-1:0]    frame_time;
    logic [CNT_W-1:0]   frame_count;
    logic [COL_W-1:0]   grid_columns;
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [ORG_W-1:0]   origin_mode;
  } sfs_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic              accept;
    logic              div_step;
    logic              update;
    logic              rect_step;
    logic              out_load;
    logic [STEP_W-1:0] step;
  } sfs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic adv_go;
  } sfs_stat_t;

endpackage

// File: rtl/core/sfs_ctrl.sv
// sfs_ctrl: item sequencing state machine and step counter.
// Depends on sfs_pkg for the command and status structs.

module sfs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  sfs_pkg::sfs_stat_t stat,
  output sfs_pkg::sfs_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_UPD  = 5'b00100,
    ST_RECT = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  localparam logic [sfs_pkg::STEP_W-1:0] LAST_DIV  =
    sfs_pkg::STEP_W'(sfs_pkg::ACC_W - 1);
  localparam logic [sfs_pkg::STEP_W-1:0] LAST_RECT =
    sfs_pkg::STEP_W'(sfs_pkg::FRAME_W - 1);

  state_t                      st, st_next;
  logic [sfs_pkg::STEP_W-1:0]  cnt, cnt_next;
  logic                        slot_free;

  assign in_stall  = (st != ST_IDLE);
  assign slot_free = !out_valid || !out_stall;

  // next state and commands
  always_comb begin
    st_next       = st;
    cnt_next      = cnt;
    cmd           = '0;
    cmd.step      = cnt;
    case (st)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          cnt_next   = '0;
          st_next    = stat.adv_go ? ST_DIV : ST_RECT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == LAST_DIV) begin
          cnt_next = '0;
          st_next  = ST_UPD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        st_next    = ST_RECT;
      end
      ST_RECT: begin
        cmd.rect_step = 1'b1;
        if (cnt == LAST_RECT) begin
          cnt_next = '0;
          st_next  = ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          st_next      = ST_IDLE;
        end
      end
      default: begin
        st_next  = ST_IDLE;
        cnt_next = '0;
      end
    endcase
  end

  // state, counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      st  <= st_next;
      cnt <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // update only follows a full division
  a_upd_after_div: assert property (@(posedge clk) disable iff (rst)
    (st == ST_UPD) |-> ($past(st) == ST_DIV && $past(cnt) == LAST_DIV))
    else $error("update entered without a full division");

  // counter rests at zero between items
  a_idle_cnt: assert property (@(posedge clk) disable iff (rst)
    (st == ST_IDLE) |-> (cnt == '0))
    else $error("step counter not cleared in idle");

  // a loaded result is presented
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result loaded but not presented");

endmodule

// File: rtl/core/sfs_datapath.sv
// sfs_datapath: animation state, serial divider with running modulo,
// grid divider and result registers. Depends on sfs_pkg.

module sfs_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  sfs_pkg::sfs_cfg_t               cfg,
  input  logic [sfs_pkg::REQ_W-1:0]       req_type,
  input  logic [sfs_pkg::DELTA_W-1:0]     delta_ms,
  input  logic [sfs_pkg::MODE_W-1:0]      anim_mode,
  input  logic                            pause_flag,
  input  sfs_pkg::sfs_cmd_t               cmd,
  output sfs_pkg::sfs_stat_t              stat,
  output logic [sfs_pkg::FRAME_W-1:0]     frame_index,
  output logic [sfs_pkg::RX_W-1:0]        rect_x,
  output logic [sfs_pkg::RY_W-1:0]        rect_y,
  output logic [sfs_pkg::OH_W-1:0]        origin_x_half,
  output logic [sfs_pkg::OH_W-1:0]        origin_y_half,
  output logic                            playing
);

  localparam int AW = sfs_pkg::ACC_W;
  localparam int FW = sfs_pkg::FRAME_W;
  localparam int NW = sfs_pkg::CNT_W;
  localparam int TW = sfs_pkg::FT_W;
  localparam int CW = sfs_pkg::COL_W;

  // animation state
  logic [AW-1:0]               acc;
  logic [FW-1:0]               frame_cur;
  logic [sfs_pkg::MODE_W-1:0]  mode_cur;
  logic                        play_on;
  logic                        paused;

  // divider and modulo working registers
  logic [AW-1:0]               dvd;
  logic [TW-1:0]               rem;
  logic [NW-1:0]               qm;
  logic [NW-1:0]               fm;
  logic [CW-1:0]               rr;
  logic [FW-1:0]               rq;

  logic [NW-1:0]               n_eff;
  logic [TW-1:0]               ft_eff;
  logic [CW-1:0]               cols_eff;
  logic [AW:0]                 acc_sum;
  logic [AW-1:0]               acc_sat;
  logic [sfs_pkg::FIDX_W-1:0]  fidx;

  // effective config values
  always_comb begin
    if (cfg.frame_count == '0) begin
      n_eff = NW'(1);
    end else if (cfg.frame_count > NW'(sfs_pkg::MAX_FRAMES)) begin
      n_eff = NW'(sfs_pkg::MAX_FRAMES);
    end else begin
      n_eff = cfg.frame_count;
    end
  end
  assign ft_eff   = (cfg.frame_time == '0) ? TW'(1) : cfg.frame_time;
  assign cols_eff = (cfg.grid_columns == '0) ? CW'(1) : cfg.grid_columns;

  // saturating accumulate and advance decision
  assign acc_sum     = {1'b0, acc} + (AW+1)'(delta_ms);
  assign acc_sat     = acc_sum[AW] ? '1 : acc_sum[AW-1:0];
  assign stat.adv_go = cfg.enable && (req_type == sfs_pkg::REQ_TICK) && !paused &&
                       (acc_sat >= AW'(ft_eff));

  // frame bit fed msb first by the step counter
  assign fidx = sfs_pkg::FIDX_W'(FW - 1) - cmd.step[sfs_pkg::FIDX_W-1:0];

  // restoring division step, quotient reduced mod n on the fly
  logic [TW:0]   rem_sh;
  logic          qbit;
  logic [NW:0]   qm_sh;
  logic [NW:0]   fm_sh;
  logic          fm_active;
  always_comb begin
    rem_sh    = {rem, dvd[AW-1]};
    qbit      = (rem_sh >= {1'b0, ft_eff});
    qm_sh     = {qm, qbit};
    fm_sh     = {fm, frame_cur[fidx]};
    fm_active = (cmd.step < sfs_pkg::STEP_W'(FW));
  end

  // grid division step
  logic [CW:0] rr_sh;
  logic        rbit;
  always_comb begin
    rr_sh = {rr, frame_cur[fidx]};
    rbit  = (rr_sh >= {1'b0, cols_eff});
  end

  // frame advance by quotient
  logic [NW:0]   sum_loop;
  logic [NW:0]   dif_loop;
  logic [AW:0]   sum_once;
  logic [FW-1:0] dif_once;
  logic [FW-1:0] frame_upd;
  logic          play_upd;
  always_comb begin
    sum_loop  = {1'b0, fm} + {1'b0, qm};
    dif_loop  = (fm >= qm) ? ({1'b0, fm} - {1'b0, qm})
                           : ({1'b0, fm} + {1'b0, n_eff} - {1'b0, qm});
    sum_once  = {1'b0, dvd} + (AW+1)'(frame_cur);
    dif_once  = frame_cur - dvd[FW-1:0];
    frame_upd = frame_cur;
    play_upd  = play_on;
    if (play_on) begin
      case (mode_cur)
        sfs_pkg::MODE_LOOP_FWD: begin
          frame_upd = (sum_loop >= {1'b0, n_eff}) ? FW'(sum_loop - {1'b0, n_eff})
                                                  : FW'(sum_loop);
        end
        sfs_pkg::MODE_LOOP_BWD: begin
          frame_upd = FW'(dif_loop);
        end
        sfs_pkg::MODE_ONCE_FWD: begin
          if (sum_once >= (AW+1)'(n_eff)) begin
            frame_upd = FW'(n_eff - 1'b1);
            play_upd  = 1'b0;
          end else begin
            frame_upd = sum_once[FW-1:0];
          end
        end
        sfs_pkg::MODE_ONCE_BWD: begin
          if (dvd > AW'(frame_cur) || {1'b0, dif_once} >= n_eff) begin
            frame_upd = '0;
            play_upd  = 1'b0;
          end else begin
            frame_upd = dif_once;
          end
        end
        default: begin
          frame_upd = frame_cur;
        end
      endcase
    end
  end

  // origin anchor in half pixels
  logic [sfs_pkg::OH_W-1:0] ox, oy;
  always_comb begin
    case (cfg.origin_mode) inside
      4'd1, 4'd4, 4'd7: ox = sfs_pkg::OH_W'(cfg.frame_width);
      4'd2, 4'd5, 4'd8: ox = {cfg.frame_width, 1'b0};
      default:          ox = '0;
    endcase
    case (cfg.origin_mode) inside
      [4'd3:4'd5]: oy = sfs_pkg::OH_W'(cfg.frame_height);
      [4'd6:4'd8]: oy = {cfg.frame_height, 1'b0};
      default:     oy = '0;
    endcase
  end

  // rectangle products
  logic [CW+sfs_pkg::DIM_W-1:0] px;
  logic [FW+sfs_pkg::DIM_W-1:0] py;
  assign px = rr * cfg.frame_width;
  assign py = rq * cfg.frame_height;

  // animation state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      frame_cur <= '0;
      mode_cur  <= sfs_pkg::MODE_LOOP_FWD;
      play_on   <= 1'b0;
      paused    <= 1'b0;
    end else if (cmd.accept && cfg.enable) begin
      case (req_type)
        sfs_pkg::REQ_TICK: begin
          acc <= acc_sat;
        end
        sfs_pkg::REQ_PLAY: begin
          mode_cur <= anim_mode;
          play_on  <= 1'b1;
          acc      <= '0;
          if (anim_mode == sfs_pkg::MODE_LOOP_BWD || anim_mode == sfs_pkg::MODE_ONCE_BWD) begin
            frame_cur <= FW'(n_eff - 1'b1);
          end else begin
            frame_cur <= '0;
          end
        end
        sfs_pkg::REQ_PAUSE: begin
          paused <= pause_flag;
        end
        sfs_pkg::REQ_MODE: begin
          mode_cur <= anim_mode;
        end
        default: begin
          acc <= acc;
        end
      endcase
    end else if (cmd.update) begin
      acc       <= '0;
      frame_cur <= frame_upd;
      play_on   <= play_upd;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dvd <= acc_sat;
      rem <= '0;
      qm  <= '0;
      fm  <= '0;
      rr  <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[AW-2:0], qbit};
      rem <= qbit ? TW'(rem_sh - {1'b0, ft_eff}) : rem_sh[TW-1:0];
      qm  <= (qm_sh >= {1'b0, n_eff}) ? NW'(qm_sh - {1'b0, n_eff}) : qm_sh[NW-1:0];
      if (fm_active) begin
        fm <= (fm_sh >= {1'b0, n_eff}) ? NW'(fm_sh - {1'b0, n_eff}) : fm_sh[NW-1:0];
      end
    end else if (cmd.rect_step) begin
      rr <= rbit ? CW'(rr_sh - {1'b0, cols_eff}) : rr_sh[CW-1:0];
      rq <= {rq[FW-2:0], rbit};
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      frame_index   <= frame_cur;
      rect_x        <= px[sfs_pkg::RX_W-1:0];
      rect_y        <= py[sfs_pkg::RY_W-1:0];
      origin_x_half <= ox;
      origin_y_half <= oy;
      playing       <= play_on;
    end
  end

endmodule

// File: rtl/core/sprite_frame_sequencer.sv
// sprite_frame_sequencer: top level with config registers, controller and datapath.
// Depends on sfs_pkg, sfs_ctrl and sfs_datapath.
// A tick that advances the frame runs 32 serial divide steps, one update, 8 grid
// divide steps and one load; any other item skips the divide and update, and the
// load waits while the output stalls. One item is in work at a time; the next is
// taken once the result sits in the output register. Reset (synchronous, active
// high) loads config defaults and clears only the control and animation state.

module sprite_frame_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sfs_pkg::REQ_W-1:0]         req_type,
  input  logic [sfs_pkg::DELTA_W-1:0]       delta_ms,
  input  logic [sfs_pkg::MODE_W-1:0]        anim_mode,
  input  logic                              pause_flag,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sfs_pkg::FRAME_W-1:0]       frame_index,
  output logic [sfs_pkg::RX_W-1:0]          rect_x,
  output logic [sfs_pkg::RY_W-1:0]          rect_y,
  output logic [sfs_pkg::OH_W-1:0]          origin_x_half,
  output logic [sfs_pkg::OH_W-1:0]          origin_y_half,
  output logic                              playing,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  sfs_pkg::sfs_cfg_t  cfg;
  sfs_pkg::sfs_cmd_t  cmd;
  sfs_pkg::sfs_stat_t stat;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable       <= 1'b1;
      cfg.frame_time   <= sfs_pkg::FT_W'(100);
      cfg.frame_count  <= sfs_pkg::CNT_W'(1);
      cfg.grid_columns <= sfs_pkg::COL_W'(1);
      cfg.frame_width  <= sfs_pkg::DIM_W'(16);
      cfg.frame_height <= sfs_pkg::DIM_W'(16);
      cfg.origin_mode  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfs_pkg::CFG_ENABLE:       cfg.enable       <= cfg_data[0];
        sfs_pkg::CFG_FRAME_TIME:   cfg.frame_time   <= cfg_data[sfs_pkg::FT_W-1:0];
        sfs_pkg::CFG_FRAME_COUNT:  cfg.frame_count  <= cfg_data[sfs_pkg::CNT_W-1:0];
        sfs_pkg::CFG_GRID_COLUMNS: cfg.grid_columns <= cfg_data[sfs_pkg::COL_W-1:0];
        sfs_pkg::CFG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[sfs_pkg::DIM_W-1:0];
        sfs_pkg::CFG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[sfs_pkg::DIM_W-1:0];
        sfs_pkg::CFG_ORIGIN_MODE:  cfg.origin_mode  <= cfg_data[sfs_pkg::ORG_W-1:0];
        default:                   cfg.enable       <= cfg.enable;
      endcase
    end
  end

  // sequencing
  sfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and state
  sfs_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .req_type      (req_type),
    .delta_ms      (delta_ms),
    .anim_mode     (anim_mode),
    .pause_flag    (pause_flag),
    .cmd           (cmd),
    .stat          (stat),
    .frame_index   (frame_index),
    .rect_x        (rect_x),
    .rect_y        (rect_y),
    .origin_x_half (origin_x_half),
    .origin_y_half (origin_y_half),
    .playing       (playing)
  );

endmodule
